/* hw/rtl/cfr_pkg.sv */
// Package for the command frame receiver: constants, phase and state types,
// and the serial CRC step. No dependencies.
package cfr_pkg;

  localparam int NAME_LEN_DEF    = 16;
  localparam int NUM_COLORS_DEF  = 8;
  localparam int NUM_ARGS_DEF    = 8;
  localparam int NUM_OPTIONS_DEF = 4;

  localparam logic [7:0] CRC_POLY = 8'h8C;

  localparam logic [7:0] CMD_IDENTIFY = 8'h00;
  localparam logic [7:0] CMD_ARG      = 8'h01;
  localparam logic [7:0] CMD_COLOR    = 8'h03;
  localparam logic [7:0] CMD_OPTION   = 8'h04;
  localparam logic [7:0] CMD_NAME     = 8'h05;
  localparam logic [7:0] CMD_SAVE     = 8'h06;
  localparam logic [7:0] TX_IDENT_TYPE = 8'h03;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN = 3'd1;
  localparam logic [2:0] ERR_RANGE   = 3'd2;
  localparam logic [2:0] ERR_SHORT   = 3'd3;
  localparam logic [2:0] ERR_CRC     = 3'd4;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_CRC,
    PH_DATA
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_STATUS,
    ST_TX_TYPE,
    ST_TX_NAME
  } state_t;

  // One bit step of the reflected CRC.
  function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
    logic [7:0] shifted;
    shifted = {1'b0, crc[7:1]};
    return (crc[0] ^ din) ? (shifted ^ CRC_POLY) : shifted;
  endfunction

endpackage

/* hw/rtl/command_frame_receiver_unit.sv */
// Top level of the command frame receiver: frame parser, bit-serial CRC,
// command execution and result output register. Depends on cfr_pkg.
//
//   channel   direction  signals
//   input     in         in_valid, in_ready, rx_byte
//   result    out        out_valid, out_ready, item_kind .. last_item
//   config    in         cfg_we, cfg_wdata (crc_enforce)
//
// Each payload byte is accepted, then shifted through the CRC shifter, one bit per
// cycle; length and CRC bytes are only accepted. A frame end issues a status
// word, and identify then one word per sent byte.
// Reset is synchronous and clears the parser, CRC and the color, argument, option and name stores.
// A stalled output holds its word; no new byte is accepted while a word waits.
module command_frame_receiver_unit #(
  parameter int NAME_LEN    = cfr_pkg::NAME_LEN_DEF,
  parameter int NUM_COLORS  = cfr_pkg::NUM_COLORS_DEF,
  parameter int NUM_ARGS    = cfr_pkg::NUM_ARGS_DEF,
  parameter int NUM_OPTIONS = cfr_pkg::NUM_OPTIONS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       item_kind,
  output logic [7:0] tx_byte,
  output logic       crc_match,
  output logic [7:0] command_code,
  output logic       save_request,
  output logic [2:0] error_code,
  output logic       last_item,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import cfr_pkg::*;

  localparam int PAY_DEPTH = (NAME_LEN + 1) > 5 ? (NAME_LEN + 1) : 5;
  localparam int NW = $clog2(NAME_LEN + 1);
  localparam int PW = $clog2(PAY_DEPTH + 1);
  // Index widths for the stores.
  localparam int PIW = $clog2(PAY_DEPTH);
  localparam int NIW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam int AIW = (NUM_ARGS > 1) ? $clog2(NUM_ARGS) : 1;
  localparam int CIW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam int OIW = (NUM_OPTIONS > 1) ? $clog2(NUM_OPTIONS) : 1;

  logic       crc_enforce;
  phase_t     phase;
  state_t     state, state_next;
  logic [7:0] bytes_left, payload_length, expected_crc, running_crc;
  logic [7:0] shreg;
  logic [2:0] bit_cnt;
  logic [PW-1:0] pos;
  logic [7:0] pbuf [PAY_DEPTH];
  logic [23:0] colors [NUM_COLORS];
  logic [7:0] args [NUM_ARGS];
  logic [7:0] opts [NUM_OPTIONS];
  logic [7:0] name [NAME_LEN];
  logic [NW-1:0] name_idx;
  logic [NW-1:0] name_idx_inc;

  // Output register.
  logic       o_kind, o_match, o_save, o_last;
  logic [7:0] o_tx, o_cmd;
  logic [2:0] o_err;

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && !out_valid;
  logic acc;
  assign acc = in_valid && in_ready;

  // Frame decode at end of frame.
  logic       match, exec, ident;
  logic [7:0] cmd, idx;
  logic [2:0] err;
  logic       save;
  always_comb begin
    match = (running_crc == expected_crc);
    cmd   = (payload_length != 8'd0) ? pbuf[0] : 8'd0;
    idx   = (payload_length > 8'd1) ? pbuf[1] : 8'd0;
    err   = ERR_OK;
    save  = 1'b0;
    ident = 1'b0;
    exec  = 1'b0;
    if (crc_enforce && !match) begin
      err = ERR_CRC;
    end else if (payload_length == 8'd0) begin
      err = ERR_SHORT;
    end else begin
      exec = 1'b1;
      case (cmd)
        CMD_IDENTIFY: ident = 1'b1;
        CMD_ARG: begin
          if (payload_length < 8'd3) err = ERR_SHORT;
          else if (32'(idx) >= NUM_ARGS) err = ERR_RANGE;
        end
        CMD_COLOR: begin
          if (payload_length < 8'd5) err = ERR_SHORT;
          else if (32'(idx) >= NUM_COLORS) err = ERR_RANGE;
        end
        CMD_OPTION: begin
          if (payload_length < 8'd3) err = ERR_SHORT;
          else if (32'(idx) >= NUM_OPTIONS) err = ERR_RANGE;
        end
        CMD_NAME: ;
        CMD_SAVE: save = 1'b1;
        default: err = ERR_UNKNOWN;
      endcase
    end
  end

  // The name ends at the store's depth or at its first zero byte.
  logic name_end;
  assign name_end = (32'(name_idx) >= NAME_LEN) ||
                    (name[name_idx[NIW-1:0]] == 8'd0);
  assign name_idx_inc = name_idx + 1'b1;

  // A new word is loaded into the output register in this cycle.
  logic out_load;
  assign out_load = out_free && ((state == ST_STATUS) || (state == ST_TX_TYPE) ||
                                 (state == ST_TX_NAME && !name_end));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && phase == PH_DATA) state_next = ST_CRC;
        else if (acc && phase == PH_CRC && payload_length == 8'd0) state_next = ST_STATUS;
      end
      ST_CRC: if (bit_cnt == 3'd7 && bytes_left == 8'd0) state_next = ST_STATUS;
              else if (bit_cnt == 3'd7) state_next = ST_IDLE;
      ST_STATUS: if (out_free) state_next = ident ? ST_TX_TYPE : ST_IDLE;
      ST_TX_TYPE: if (out_free) state_next = ST_TX_NAME;
      ST_TX_NAME: if (out_free && name_end) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_enforce <= 1'b0;
      phase <= PH_LEN;
      bytes_left <= '0;
      payload_length <= '0;
      expected_crc <= '0;
      running_crc <= '0;
      out_valid <= 1'b0;
      bit_cnt <= '0;
      pos <= '0;
      name_idx <= '0;
      for (int i = 0; i < NUM_COLORS; i++) colors[i] <= '0;
      for (int i = 0; i < NUM_ARGS; i++) args[i] <= '0;
      for (int i = 0; i < NUM_OPTIONS; i++) opts[i] <= '0;
      for (int i = 0; i < NAME_LEN; i++) name[i] <= '0;
    end else begin
      if (cfg_we) crc_enforce <= cfg_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (phase)
              PH_LEN: begin
                payload_length <= rx_byte;
                bytes_left <= rx_byte;
                phase <= PH_CRC;
              end
              PH_CRC: begin
                expected_crc <= rx_byte;
                running_crc <= '0;
                pos <= '0;
                phase <= (payload_length == 8'd0) ? PH_LEN : PH_DATA;
              end
              default: begin
                if (32'(pos) < PAY_DEPTH) begin
                  pbuf[pos[PIW-1:0]] <= rx_byte;
                  pos <= pos + 1'b1;
                end
                shreg <= rx_byte;
                bit_cnt <= '0;
                bytes_left <= bytes_left - 8'd1;
              end
            endcase
          end
        end
        ST_CRC: begin
          running_crc <= crc_bit(running_crc, shreg[0]);
          shreg <= {1'b0, shreg[7:1]};
          bit_cnt <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7 && bytes_left == 8'd0) phase <= PH_LEN;
        end
        ST_STATUS: begin
          if (out_free) begin
            o_kind <= 1'b0; o_tx <= '0; o_match <= match; o_cmd <= cmd;
            o_save <= save; o_err <= err; o_last <= !ident;
            name_idx <= '0;
            if (exec && err == ERR_OK) begin
              case (cmd)
                CMD_ARG: args[idx[AIW-1:0]] <= pbuf[2];
                CMD_OPTION: opts[idx[OIW-1:0]] <= pbuf[2];
                CMD_COLOR: colors[idx[CIW-1:0]] <= {pbuf[2], pbuf[3], pbuf[4]};
                CMD_NAME: begin
                  for (int i = 0; i < NAME_LEN; i++)
                    if (i + 1 < 32'(payload_length)) name[i] <= pbuf[i + 1];
                end
                default: ;
              endcase
            end
          end
        end
        ST_TX_TYPE: begin
          if (out_free) begin
            o_kind <= 1'b1; o_tx <= TX_IDENT_TYPE; o_match <= 1'b0; o_cmd <= '0;
            o_save <= 1'b0; o_err <= ERR_OK; o_last <= name_end;
            // Peek: if the name is empty this is the last word.
          end
        end
        ST_TX_NAME: begin
          if (out_free && !name_end) begin
            o_kind <= 1'b1; o_tx <= name[name_idx[NIW-1:0]];
            o_match <= 1'b0; o_cmd <= '0; o_save <= 1'b0; o_err <= ERR_OK;
            o_last <= (32'(name_idx_inc) >= NAME_LEN) ||
                      (name[name_idx_inc[NIW-1:0]] == 8'd0);
            name_idx <= name_idx_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign item_kind = o_kind;
  assign tx_byte = o_tx;
  assign crc_match = o_match;
  assign command_code = o_cmd;
  assign save_request = o_save;
  assign error_code = o_err;
  assign last_item = o_last;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready) else $error("byte taken while busy");
  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && item_kind) |-> (error_code == ERR_OK && !save_request))
    else $error("transmit word carries status");
  a_crc_len: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC) |=> (state == ST_CRC || bit_cnt == 3'd0)) else $error("crc count");
`endif
endmodule
